// File: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define DPD_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/dpd_pkg.sv
// Constants, status codes and helper functions for the debug packet deframer.
// No dependencies; used by debug_packet_deframer.
package dpd_pkg;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_HASH   = 8'h23;
	localparam logic [7:0] CHAR_ESCAPE = 8'h7d;
	localparam logic [7:0] CHAR_DOT    = 8'h2e;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_STRAY_HASH    = 3'd1;
	localparam logic [2:0] ST_DOLLAR_INSIDE = 3'd2;
	localparam logic [2:0] ST_OVERFLOW      = 3'd3;
	localparam logic [2:0] ST_BAD_HEX       = 3'd4;
	localparam logic [2:0] ST_MISMATCH      = 3'd5;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam int          ADDR_W          = 3;
	localparam logic        REG_MAX_PAYLOAD = 1'b0;
	localparam logic        REG_ACCEPT_DOTS = 1'b1;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;
	localparam logic        ACCEPT_DOTS_RST = 1'b1;

	// Returns {valid, nibble} for an ASCII hex digit.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// File: rtl/debug_packet_deframer.sv
// Debug packet deframer top level: framing state, checksum check, output register.
// Depends on dpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

// One received byte enters per cycle and is processed in that cycle: the framing
// state updates at the accept edge and any result lands in a single output
// register, so the sustained rate is one byte per clock as long as the output
// side takes results. A payload byte gives a kind 0 word with the unescaped byte;
// the second checksum character, a stray '#', a '$' inside a packet or an
// overflow of max_payload gives a kind 1 word with status and length. in_stall is
// high only while a result waits in the output register and out_stall is high.
module debug_packet_deframer import dpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [7:0]        data_byte,
	output logic [2:0]        status,
	output logic [15:0]       payload_length
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CHECK1  = 2'd2,
		PH_CHECK2  = 2'd3
	} phase_t;

	logic [15:0] max_payload_q;
	logic        accept_dots_q;
	phase_t      phase_q, phase_d;
	logic        escape_q, escape_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  first_q, first_d;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  data_q;
	logic [2:0]  status_q;
	logic [15:0] length_q;

	logic        res_valid;
	logic        res_kind;
	logic [7:0]  res_data;
	logic [2:0]  res_status;
	logic        accept;
	logic        cfg_write;
	logic [4:0]  hi_nib, lo_nib;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_ACCEPT_DOTS) ? {31'd0, accept_dots_q}
	                                                 : {16'd0, max_payload_q};

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign hi_nib = hex_nibble(first_q);
	assign lo_nib = hex_nibble(rx_byte);

	always_comb begin
		phase_d    = phase_q;
		escape_d   = escape_q;
		count_d    = count_q;
		sum_d      = sum_q;
		first_d    = first_q;
		res_valid  = 1'b0;
		res_kind   = KIND_END;
		res_data   = 8'd0;
		res_status = ST_OK;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == CHAR_DOLLAR) begin
					phase_d = PH_PAYLOAD;
				end else if (rx_byte == CHAR_HASH) begin
					res_valid  = 1'b1;
					res_status = ST_STRAY_HASH;
				end
			end
			PH_PAYLOAD: begin
				if (escape_q) begin
					escape_d  = 1'b0;
					res_valid = 1'b1;
					res_kind  = KIND_BYTE;
				end else if (rx_byte == CHAR_DOLLAR) begin
					res_valid  = 1'b1;
					res_status = ST_DOLLAR_INSIDE;
				end else if (rx_byte == CHAR_HASH) begin
					phase_d = PH_CHECK1;
				end else if (count_q >= max_payload_q) begin
					res_valid  = 1'b1;
					res_status = ST_OVERFLOW;
				end else if (rx_byte == CHAR_ESCAPE) begin
					escape_d = 1'b1;
				end else begin
					res_valid = 1'b1;
					res_kind  = KIND_BYTE;
				end
				if (res_valid && res_kind == KIND_BYTE) begin
					res_data = rx_byte;
					count_d  = count_q + 16'd1;
					sum_d    = sum_q + rx_byte;
				end
			end
			PH_CHECK1: begin
				first_d = rx_byte;
				phase_d = PH_CHECK2;
			end
			PH_CHECK2: begin
				res_valid = 1'b1;
				if (accept_dots_q && first_q == CHAR_DOT && rx_byte == CHAR_DOT) begin
					res_status = ST_OK;
				end else if (!hi_nib[4] || !lo_nib[4]) begin
					res_status = ST_BAD_HEX;
				end else if ({hi_nib[3:0], lo_nib[3:0]} != sum_q) begin
					res_status = ST_MISMATCH;
				end else begin
					res_status = ST_OK;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		// Any end result, and a new '$' while hunting, start from a clean frame.
		if ((res_valid && res_kind == KIND_END) ||
		    (phase_q == PH_HUNT && rx_byte == CHAR_DOLLAR)) begin
			escape_d = 1'b0;
			count_d  = 16'd0;
			sum_d    = 8'd0;
			first_d  = 8'd0;
			if (res_valid) begin
				phase_d = PH_HUNT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			accept_dots_q <= ACCEPT_DOTS_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_MAX_PAYLOAD: max_payload_q <= pwdata[15:0];
				REG_ACCEPT_DOTS: accept_dots_q <= pwdata[0];
				default:         max_payload_q <= max_payload_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			escape_q <= 1'b0;
			count_q  <= 16'd0;
			sum_q    <= 8'd0;
			first_q  <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			escape_q <= escape_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			first_q  <= first_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			kind_q   <= res_kind;
			data_q   <= res_data;
			status_q <= (res_kind == KIND_END) ? res_status : ST_OK;
			length_q <= (res_kind == KIND_END) ? count_q : 16'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign data_byte      = data_q;
	assign status         = status_q;
	assign payload_length = length_q;

	`DPD_ASSERT(a_escape_in_payload, escape_q |-> phase_q == PH_PAYLOAD, "escape outside payload")
	`DPD_ASSERT(a_hunt_clean, phase_q == PH_HUNT |-> (count_q == 16'd0 && sum_q == 8'd0), "dirty hunt state")
	`DPD_ASSERT(a_byte_word_clean, (out_valid && kind == KIND_BYTE) |-> (status == ST_OK && payload_length == 16'd0), "byte word carries end fields")
	`DPD_ASSERT(a_end_word_clean, (out_valid && kind == KIND_END) |-> (data_byte == 8'd0 && status <= ST_MISMATCH), "bad end word")
	`DPD_ASSERT(a_end_restarts, (accept && res_valid && res_kind == KIND_END) |=> phase_q == PH_HUNT, "no restart after end")

endmodule

// File: tb/tb_debug_packet_deframer.sv
// Self-checking testbench for debug_packet_deframer: feeds framed and broken byte streams and
// checks every output word against an in-bench predictor or, for pinned rows, the pinned word.
// Depends on dpd_pkg and the debug_packet_deframer RTL.
module tb_debug_packet_deframer import dpd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_PAYLOAD,
		PH_CHECK1,
		PH_CHECK2
	} frame_phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [2:0]  st;
		logic [15:0] len;
	} word_t;

	typedef struct packed {
		logic [7:0] b;
		logic       pin;
		word_t      w;
	} stim_row_t;

	localparam int HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_ITEMS = 1120;
	localparam int NUM_PHASES = 5;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic              kind;
	logic [7:0]        data_byte;
	logic [2:0]        status;
	logic [15:0]       payload_length;

	debug_packet_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data_byte      (data_byte),
		.status         (status),
		.payload_length (payload_length)
	);

	// Predictor state and its copy of the registers.
	frame_phase_t fr_phase;
	logic         fr_esc;
	logic [15:0]  fr_count;
	logic [7:0]   fr_sum;
	logic [7:0]   fr_first;
	logic [15:0]  cfg_max;
	logic         cfg_dots;

	word_t pending_words[$];
	int    fail_count;
	int    sent_items;
	int    snd_idle_pct;
	int    rcv_idle_pct;
	bit    hold_req;

	// Pinned expectation for directed rows, set while the byte is offered.
	bit    pin_on;
	word_t pin_word;

	stim_row_t dir_tab [26] = '{
		'{8'h00,       1'b0, '0},
		'{CHAR_HASH,   1'b1, '{KIND_END, 8'h00, ST_STRAY_HASH, 16'd0}},
		'{CHAR_DOLLAR, 1'b0, '0},
		'{8'h00,       1'b1, '{KIND_BYTE, 8'h00, ST_OK, 16'd0}},
		'{8'hff,       1'b1, '{KIND_BYTE, 8'hff, ST_OK, 16'd0}},
		'{CHAR_ESCAPE, 1'b0, '0},
		'{CHAR_DOLLAR, 1'b1, '{KIND_BYTE, CHAR_DOLLAR, ST_OK, 16'd0}},
		'{CHAR_ESCAPE, 1'b0, '0},
		'{CHAR_ESCAPE, 1'b1, '{KIND_BYTE, CHAR_ESCAPE, ST_OK, 16'd0}},
		'{CHAR_HASH,   1'b0, '0},
		'{"A",         1'b0, '0},
		'{"0",         1'b0, '0},
		'{CHAR_DOLLAR, 1'b0, '0},
		'{CHAR_HASH,   1'b0, '0},
		'{CHAR_DOT,    1'b0, '0},
		'{CHAR_DOT,    1'b1, '{KIND_END, 8'h00, ST_OK, 16'd0}},
		'{CHAR_DOLLAR, 1'b0, '0},
		'{CHAR_HASH,   1'b0, '0},
		'{"g",         1'b0, '0},
		'{"0",         1'b1, '{KIND_END, 8'h00, ST_BAD_HEX, 16'd0}},
		'{CHAR_DOLLAR, 1'b0, '0},
		'{CHAR_HASH,   1'b0, '0},
		'{"0",         1'b0, '0},
		'{"1",         1'b1, '{KIND_END, 8'h00, ST_MISMATCH, 16'd0}},
		'{CHAR_DOLLAR, 1'b0, '0},
		'{CHAR_DOLLAR, 1'b1, '{KIND_END, 8'h00, ST_DOLLAR_INSIDE, 16'd0}}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("debug_packet_deframer test failed");
		$finish;
	end

	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) begin
			return 8'("0" + v);
		end
		return 8'((upper ? "A" : "a") + v - 8'd10);
	endfunction

	function automatic void clear_frame();
		fr_phase = PH_HUNT;
		fr_esc   = 1'b0;
		fr_count = 16'd0;
		fr_sum   = 8'd0;
		fr_first = 8'd0;
	endfunction

	// Builds the end-of-packet word and drops back to hunting.
	function automatic word_t end_packet(input logic [2:0] st);
		word_t w;
		w = '{KIND_END, 8'h00, st, fr_count};
		clear_frame();
		return w;
	endfunction

	task automatic deframe(input logic [7:0] b, output bit has, output word_t w);
		logic [3:0] hi;
		logic [3:0] lo;
		bit ok_hi;
		bit ok_lo;
		has = 1'b0;
		w = '0;
		case (fr_phase)
			PH_HUNT: begin
				if (b == CHAR_DOLLAR) begin
					clear_frame();
					fr_phase = PH_PAYLOAD;
				end else if (b == CHAR_HASH) begin
					w = end_packet(ST_STRAY_HASH);
					has = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (!fr_esc && b == CHAR_DOLLAR) begin
					w = end_packet(ST_DOLLAR_INSIDE);
					has = 1'b1;
				end else if (!fr_esc && b == CHAR_HASH) begin
					fr_phase = PH_CHECK1;
				end else if (!fr_esc && fr_count >= cfg_max) begin
					w = end_packet(ST_OVERFLOW);
					has = 1'b1;
				end else if (!fr_esc && b == CHAR_ESCAPE) begin
					fr_esc = 1'b1;
				end else begin
					fr_esc = 1'b0;
					fr_count = fr_count + 16'd1;
					fr_sum = fr_sum + b;
					w = '{KIND_BYTE, b, ST_OK, 16'd0};
					has = 1'b1;
				end
			end
			PH_CHECK1: begin
				fr_first = b;
				fr_phase = PH_CHECK2;
			end
			default: begin
				has = 1'b1;
				ok_hi = hex_digit(fr_first, hi);
				ok_lo = hex_digit(b, lo);
				if (cfg_dots && fr_first == CHAR_DOT && b == CHAR_DOT) begin
					w = end_packet(ST_OK);
				end else if (!ok_hi || !ok_lo) begin
					w = end_packet(ST_BAD_HEX);
				end else if ({hi, lo} != fr_sum) begin
					w = end_packet(ST_MISMATCH);
				end else begin
					w = end_packet(ST_OK);
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		bit    has;
		word_t w;
		word_t got;
		word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{kind, data_byte, status, payload_length};
				if (pending_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected word: kind %0d data %02h status %0d length %0d",
							got.kind, got.data, got.st, got.len);
					end
				end else begin
					want = pending_words.pop_front();
					if (got.kind !== want.kind || got.data !== want.data ||
							got.st !== want.st || got.len !== want.len) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("word mismatch: kind %0d/%0d data %02h/%02h status %0d/%0d length %0d/%0d (expected/actual)",
								want.kind, got.kind, want.data, got.data,
								want.st, got.st, want.len, got.len);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				deframe(rx_byte, has, w);
				if (pin_on) begin
					pending_words.push_back(pin_word);
				end else if (has) begin
					pending_words.push_back(w);
				end
			end
		end
	end

	// Receiver: random stalls, or one long hold-off when requested.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	// Offers one byte and returns at the edge where it is taken.
	task automatic send_byte(input logic [7:0] b, input bit pin = 1'b0, input word_t pw = '0);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pin_on = pin;
		pin_word = pw;
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_packet(input int n);
		logic [7:0] sum;
		logic [7:0] b;
		int mode;
		bit upper;
		sum = 8'd0;
		send_byte(CHAR_DOLLAR);
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(255));
			// Now and then a bare dollar breaks the frame.
			if ($urandom_range(99) < 3) begin
				send_byte(CHAR_DOLLAR);
			end
			if (b == CHAR_DOLLAR || b == CHAR_HASH || b == CHAR_ESCAPE ||
					$urandom_range(19) == 0) begin
				send_byte(CHAR_ESCAPE);
			end
			send_byte(b);
			sum = sum + b;
		end
		send_byte(CHAR_HASH);
		mode = $urandom_range(99);
		upper = 1'($urandom_range(1));
		if (mode < 70) begin
			send_byte(hex_char(sum[7:4], upper));
			send_byte(hex_char(sum[3:0], upper));
		end else if (mode < 80) begin
			send_byte(CHAR_DOT);
			send_byte(CHAR_DOT);
		end else if (mode < 90) begin
			send_byte(hex_char(~sum[7:4], upper));
			send_byte(hex_char(sum[3:0], upper));
		end else begin
			send_byte(8'($urandom_range(255)));
			send_byte(8'($urandom_range(255)));
		end
	endtask

	// Drops valid and waits until every expected word has come out.
	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		pin_on = 1'b0;
		while (pending_words.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_access(input logic [ADDR_W-1:0] a, input bit wr,
			input logic [31:0] d, output logic [31:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_reg(input logic [ADDR_W-1:0] a, input logic [31:0] d);
		logic [31:0] rd;
		reg_access(a, 1'b1, d, rd);
		reg_access(a, 1'b0, 32'd0, rd);
		if (rd !== d) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("register %0d reads %08h, wrote %08h", a, rd, d);
			end
		end
	endtask

	task automatic configure(input logic [15:0] max_len, input logic dots);
		settle();
		set_reg(ADDR_W'(4 * REG_MAX_PAYLOAD), {16'd0, max_len});
		set_reg(ADDR_W'(4 * REG_ACCEPT_DOTS), {31'd0, dots});
		cfg_max = max_len;
		cfg_dots = dots;
	endtask

	initial begin
		logic [15:0] ph_max [NUM_PHASES];
		logic        ph_dots [NUM_PHASES];
		int          target;
		int          len;
		ph_max = '{16'd1024, 16'd0, 16'hffff, 16'd5, 16'd0};
		ph_dots = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		pin_on = 1'b0;
		pin_word = '0;
		hold_req = 1'b0;
		fail_count = 0;
		sent_items = 0;
		snd_idle_pct = 23;
		rcv_idle_pct = 23;
		cfg_max = MAX_PAYLOAD_RST;
		cfg_dots = ACCEPT_DOTS_RST;
		clear_frame();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			send_byte(dir_tab[i].b, dir_tab[i].pin, dir_tab[i].w);
		end

		target = sent_items;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1) begin
				ph_max[p] = 16'($urandom_range(1, 30));
				ph_dots[p] = 1'($urandom_range(1));
			end
			configure(ph_max[p], ph_dots[p]);
			// One phase runs with no idling on either side.
			snd_idle_pct = (p == 3) ? 0 : 23;
			rcv_idle_pct = (p == 3) ? 0 : 23;
			if (ph_max[p] == 16'hffff) begin
				// The receiver holds off while a long packet keeps coming in.
				hold_req = 1'b1;
				send_packet(60);
			end
			target += RANDOM_ITEMS / NUM_PHASES;
			while (sent_items < target) begin
				if ($urandom_range(99) < 85) begin
					len = ($urandom_range(19) == 0) ? $urandom_range(13, 70) :
						$urandom_range(0, 12);
					send_packet(len);
				end else begin
					repeat ($urandom_range(1, 3)) begin
						send_byte(($urandom_range(3) == 0) ? CHAR_HASH :
							8'($urandom_range(255)));
					end
				end
			end
		end

		settle();
		fail_count += pending_words.size();
		if (fail_count == 0) begin
			$display("debug_packet_deframer test passed");
		end else begin
			$display("debug_packet_deframer test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/dpd_pkg.sv
rtl/debug_packet_deframer.sv
tb/tb_debug_packet_deframer.sv
